FILE: hw/rtl/group_dependency_dispatch_scheduler_assert.svh
// assertion macros for the dispatch scheduler
`ifndef GROUP_DEPENDENCY_DISPATCH_SCHEDULER_ASSERT_SVH
`define GROUP_DEPENDENCY_DISPATCH_SCHEDULER_ASSERT_SVH

// same-cycle implication
`define GDDS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define GDDS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

FILE: hw/rtl/gdds_pkg.sv
// ----------------------------------------------------------------------------
// gdds_pkg
// types, sizes and helpers for the group dependency dispatch scheduler
// ----------------------------------------------------------------------------
package gdds_pkg;

  localparam int SLOTS   = 64;
  localparam int GROUPS  = 64;
  localparam int BATCHES = 16;

  // successor links for every slot and group, then one tail entry per group
  localparam int LINK_DEPTH = SLOTS * GROUPS + GROUPS;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LINK_W  = $clog2(SLOTS + 1);
  localparam int GRP_W   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BATCH_W = (BATCHES > 1) ? $clog2(BATCHES) : 1;
  localparam int DEG_W   = $clog2(GROUPS + 1);
  localparam int LADDR_W = $clog2(LINK_DEPTH);
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam logic [LINK_W-1:0] EMPTY_LINK = LINK_W'(SLOTS);

  typedef enum logic [1:0] {
    CMD_OPEN     = 2'd0,
    CMD_SUBMIT   = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_RSVD     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_DISP = 1'b1
  } kind_e;

  typedef struct packed {
    logic [31:0]        seq;
    logic [GROUPS-1:0]  mask;
    logic [BATCH_W-1:0] batch;
    logic [DEG_W-1:0]   indeg;
  } slot_rec_t;

  typedef struct packed {
    status_e     status;
    kind_e       kind;
    logic [31:0] txn_id;
    logic        ready_now;
    logic        batch_done;
    logic [3:0]  done_batch;
    logic        last;
  } result_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } age_ctl_t;

  function automatic result_t make_res(status_e st, kind_e kd, logic [31:0] id,
                                       logic rdy, logic bd, logic [3:0] bn,
                                       logic lst);
    result_t r;
    r.status     = st;
    r.kind       = kd;
    r.txn_id     = id;
    r.ready_now  = rdy;
    r.batch_done = bd;
    r.done_batch = bn;
    r.last       = lst;
    return r;
  endfunction

  function automatic logic [LADDR_W-1:0] link_addr(logic [SLOT_W-1:0] s,
                                                   logic [GRP_W-1:0] g);
    return LADDR_W'(LADDR_W'(s) * LADDR_W'(GROUPS)) + LADDR_W'(g);
  endfunction

  function automatic logic [LADDR_W-1:0] tail_addr(logic [GRP_W-1:0] g);
    return LADDR_W'(SLOTS * GROUPS) + LADDR_W'(g);
  endfunction

endpackage

FILE: hw/rtl/gdds_if.sv
// ----------------------------------------------------------------------------
// gdds_in_if / gdds_out_if
// valid/ready channels for commands and results
// ----------------------------------------------------------------------------
interface gdds_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  batch_tag;
  logic [15:0] batch_count;
  logic [63:0] group_mask;
  logic [31:0] done_id;

  modport source (output valid, command, batch_tag, batch_count, group_mask, done_id,
                  input ready);
  modport sink (input valid, command, batch_tag, batch_count, group_mask, done_id,
                output ready);
endinterface

interface gdds_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        kind;
  logic [31:0] txn_id;
  logic        ready_now;
  logic        batch_done;
  logic [3:0]  done_batch;
  logic        last;

  modport source (output valid, status, kind, txn_id, ready_now, batch_done, done_batch,
                  last, input ready);
  modport sink (input valid, status, kind, txn_id, ready_now, batch_done, done_batch,
                last, output ready);
endinterface

FILE: hw/rtl/group_dependency_dispatch_scheduler.sv
// ----------------------------------------------------------------------------
// group_dependency_dispatch_scheduler
// conflict-group dependency scoreboard with slot and link memories
// ----------------------------------------------------------------------------
//  port    | dir | carries
//  in_i    | in  | command, batch_tag, batch_count, group_mask, done_id
//  out_o   | out | status, kind, txn_id, ready_now, batch_done, done_batch, last
//
// one command at a time. open batch: an ack. submit: walks every group; a named
// group: clear the slot's link, read the tail, make the new slot the tail and,
// if there was a tail, link the old one to the new slot; then an ack. complete:
// searches the slot memory for the id, then walks every group with tail check,
// link read and indegree update per named group, then the batch count, the ack
// and the dispatches. a stalled output holds the sequencer at its next result.
// reset clears busy bits, group tail valid bits, batch counts; no clearing pass.
`include "group_dependency_dispatch_scheduler_assert.svh"

module group_dependency_dispatch_scheduler import gdds_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  gdds_in_if.sink    in_i,
  gdds_out_if.source out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_OPEN, S_BADCMD, S_FULL, S_SUB_G, S_SUB_T, S_SUB_L, S_SUB_FIN,
    S_CMP_RD, S_CMP_CHK, S_CMP_BADID, S_CMP_G, S_CMP_TL, S_CMP_LNK, S_CMP_SLT,
    S_CMP_BATCH, S_CMP_ACK, S_CMP_DSP
  } state_e;

  state_e             state_q;
  logic [BATCH_W-1:0] bidx_q;
  logic [15:0]        bcount_q;
  logic [GROUPS-1:0]  mask_q;
  logic [31:0]        id_q;
  logic [SLOTS-1:0]   busy_q;
  logic [GROUPS-1:0]  tail_vld_q;
  logic [15:0]        brem_q [BATCHES];
  logic [31:0]        next_seq_q;
  logic [SLOT_W-1:0]  slot_q, t_q, sc_q;
  logic [GRP_W-1:0]   g_q;
  logic [DEG_W-1:0]   deg_q;
  slot_rec_t          rec_q;
  logic               bdone_q;
  result_t            out_q;
  logic               out_valid_q;

  // memories
  slot_rec_t          slot_mem [SLOTS];
  slot_rec_t          slot_rd_q;
  logic [LINK_W-1:0]  link_mem [LINK_DEPTH];
  logic [LINK_W-1:0]  link_rd_q;

  logic               slot_we;
  logic [SLOT_W-1:0]  slot_waddr, slot_raddr;
  slot_rec_t          slot_wdata;
  logic               link_we;
  logic [LADDR_W-1:0] link_waddr, link_raddr;
  logic [LINK_W-1:0]  link_wdata;

  logic               out_free;
  logic               out_load;
  logic               free_ok;
  logic [SLOT_W-1:0]  free_idx;
  logic               g_last;
  logic [LINK_W-1:0]  tail_cur;
  logic [SLOT_W-1:0]  lnk_slot;
  logic               lnk_hit;
  age_ctl_t           age_ctl;
  logic [31:0]        age_in, age_head;
  logic [CNT_W-1:0]   age_cnt;
  logic [BATCH_W-1:0] in_bidx;

  assign out_free   = !out_valid_q || out_o.ready;
  assign out_load   = out_free && ((state_q == S_OPEN) || (state_q == S_BADCMD) ||
                                   (state_q == S_FULL) || (state_q == S_SUB_FIN) ||
                                   (state_q == S_CMP_BADID) || (state_q == S_CMP_ACK) ||
                                   (state_q == S_CMP_DSP));
  assign g_last     = (g_q == GRP_W'(GROUPS - 1));
  assign tail_cur   = tail_vld_q[g_q] ? link_rd_q : EMPTY_LINK;
  assign lnk_slot   = link_rd_q[SLOT_W-1:0];
  assign lnk_hit    = (link_rd_q < EMPTY_LINK) && busy_q[lnk_slot];
  assign in_bidx    = BATCH_W'(32'(in_i.batch_tag) % BATCHES);
  assign in_i.ready = (state_q == S_IDLE);

  // lowest free slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = slot_q;
    slot_wdata = slot_rd_q;
    slot_raddr = sc_q;
    link_we    = 1'b0;
    link_waddr = link_addr(slot_q, g_q);
    link_wdata = EMPTY_LINK;
    link_raddr = link_addr(slot_q, g_q);
    age_ctl    = '0;
    age_in     = next_seq_q - slot_rd_q.seq;
    unique case (state_q)
      S_IDLE: age_ctl.clear = 1'b1;
      S_SUB_G: begin
        // clear own link and fetch the group tail
        link_raddr = tail_addr(g_q);
        link_we    = mask_q[g_q];
      end
      S_SUB_T: begin
        link_we    = 1'b1;
        link_waddr = tail_addr(g_q);
        link_wdata = LINK_W'(slot_q);
      end
      S_SUB_L: begin
        link_we    = 1'b1;
        link_waddr = link_addr(t_q, g_q);
        link_wdata = LINK_W'(slot_q);
      end
      S_SUB_FIN: begin
        slot_we          = out_free;
        slot_wdata.seq   = next_seq_q;
        slot_wdata.mask  = mask_q;
        slot_wdata.batch = bidx_q;
        slot_wdata.indeg = deg_q;
      end
      S_CMP_G: link_raddr = tail_addr(g_q);
      S_CMP_LNK: slot_raddr = lnk_slot;
      S_CMP_SLT: begin
        slot_waddr       = t_q;
        slot_we          = (slot_rd_q.indeg != '0);
        slot_wdata.indeg = slot_rd_q.indeg - DEG_W'(1);
        age_ctl.push     = (slot_rd_q.indeg == DEG_W'(1));
      end
      S_CMP_DSP: age_ctl.pop = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd_q <= link_mem[link_raddr];
  end

  gdds_age_list u_age_list (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (age_ctl),
    .age_i   (age_in),
    .head_o  (age_head),
    .count_o (age_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= '0;
      tail_vld_q  <= '0;
      next_seq_q  <= 32'd1;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      bidx_q      <= '0;
      bcount_q    <= '0;
      mask_q      <= '0;
      id_q        <= '0;
      slot_q      <= '0;
      t_q         <= '0;
      sc_q        <= '0;
      g_q         <= '0;
      deg_q       <= '0;
      rec_q       <= '0;
      bdone_q     <= 1'b0;
      for (int b = 0; b < BATCHES; b++) begin
        brem_q[b] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            bidx_q   <= in_bidx;
            bcount_q <= in_i.batch_count;
            mask_q   <= in_i.group_mask[GROUPS-1:0];
            id_q     <= in_i.done_id;
            g_q      <= '0;
            deg_q    <= '0;
            sc_q     <= '0;
            slot_q   <= free_idx;
            unique case (cmd_e'(in_i.command))
              CMD_OPEN:     state_q <= S_OPEN;
              CMD_SUBMIT:   state_q <= free_ok ? S_SUB_G : S_FULL;
              CMD_COMPLETE: state_q <= S_CMP_RD;
              default:      state_q <= S_BADCMD;
            endcase
          end
        end
        S_OPEN: begin
          if (out_free) begin
            brem_q[bidx_q] <= bcount_q;
            out_q          <= make_res(ST_OK, KIND_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
            state_q        <= S_IDLE;
          end
        end
        S_BADCMD: begin
          if (out_free) begin
            out_q   <= make_res(ST_BAD, KIND_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
            state_q <= S_IDLE;
          end
        end
        S_FULL: begin
          if (out_free) begin
            out_q   <= make_res(ST_FULL, KIND_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
            state_q <= S_IDLE;
          end
        end
        S_SUB_G: begin
          if (mask_q[g_q]) begin
            state_q <= S_SUB_T;
          end else if (g_last) begin
            state_q <= S_SUB_FIN;
          end else begin
            g_q <= g_q + GRP_W'(1);
          end
        end
        S_SUB_T: begin
          // new slot becomes the tail, the old tail gets linked next
          tail_vld_q[g_q] <= 1'b1;
          if (tail_cur != EMPTY_LINK) begin
            t_q     <= tail_cur[SLOT_W-1:0];
            deg_q   <= deg_q + DEG_W'(1);
            state_q <= S_SUB_L;
          end else if (g_last) begin
            state_q <= S_SUB_FIN;
          end else begin
            g_q     <= g_q + GRP_W'(1);
            state_q <= S_SUB_G;
          end
        end
        S_SUB_L: begin
          if (g_last) begin
            state_q <= S_SUB_FIN;
          end else begin
            g_q     <= g_q + GRP_W'(1);
            state_q <= S_SUB_G;
          end
        end
        S_SUB_FIN: begin
          if (out_free) begin
            busy_q[slot_q] <= 1'b1;
            next_seq_q     <= next_seq_q + 32'd1;
            out_q          <= make_res(ST_OK, KIND_ACK, next_seq_q, deg_q == '0,
                                       1'b0, '0, 1'b1);
            state_q        <= S_IDLE;
          end
        end
        S_CMP_RD: state_q <= S_CMP_CHK;
        S_CMP_CHK: begin
          if (busy_q[sc_q] && (slot_rd_q.seq == id_q)) begin
            slot_q <= sc_q;
            rec_q  <= slot_rd_q;
            if (slot_rd_q.indeg != '0) begin
              state_q <= S_CMP_BADID;
            end else begin
              busy_q[sc_q] <= 1'b0;
              state_q      <= S_CMP_G;
            end
          end else if (sc_q == SLOT_W'(SLOTS - 1)) begin
            state_q <= S_CMP_BADID;
          end else begin
            sc_q    <= sc_q + SLOT_W'(1);
            state_q <= S_CMP_RD;
          end
        end
        S_CMP_BADID: begin
          if (out_free) begin
            out_q   <= make_res(ST_BAD, KIND_ACK, id_q, 1'b0, 1'b0, '0, 1'b1);
            state_q <= S_IDLE;
          end
        end
        S_CMP_G: begin
          if (rec_q.mask[g_q]) begin
            state_q <= S_CMP_TL;
          end else if (g_last) begin
            state_q <= S_CMP_BATCH;
          end else begin
            g_q <= g_q + GRP_W'(1);
          end
        end
        S_CMP_TL: begin
          if (tail_cur == LINK_W'(slot_q)) begin
            tail_vld_q[g_q] <= 1'b0;
          end
          state_q <= S_CMP_LNK;
        end
        S_CMP_LNK: begin
          if (lnk_hit) begin
            t_q     <= lnk_slot;
            state_q <= S_CMP_SLT;
          end else if (g_last) begin
            state_q <= S_CMP_BATCH;
          end else begin
            g_q     <= g_q + GRP_W'(1);
            state_q <= S_CMP_G;
          end
        end
        S_CMP_SLT: begin
          if (g_last) begin
            state_q <= S_CMP_BATCH;
          end else begin
            g_q     <= g_q + GRP_W'(1);
            state_q <= S_CMP_G;
          end
        end
        S_CMP_BATCH: begin
          bdone_q <= (brem_q[rec_q.batch] == 16'd1);
          if (brem_q[rec_q.batch] != '0) begin
            brem_q[rec_q.batch] <= brem_q[rec_q.batch] - 16'd1;
          end
          state_q <= S_CMP_ACK;
        end
        S_CMP_ACK: begin
          if (out_free) begin
            out_q   <= make_res(ST_OK, KIND_ACK, id_q, 1'b0,
                                (age_cnt == '0) && bdone_q,
                                ((age_cnt == '0) && bdone_q) ? 4'(rec_q.batch) : 4'd0,
                                age_cnt == '0);
            state_q <= (age_cnt == '0) ? S_IDLE : S_CMP_DSP;
          end
        end
        S_CMP_DSP: begin
          if (out_free) begin
            out_q <= make_res(ST_OK, KIND_DISP, next_seq_q - age_head, 1'b0,
                              (age_cnt == CNT_W'(1)) && bdone_q,
                              ((age_cnt == CNT_W'(1)) && bdone_q) ?
                                4'(rec_q.batch) : 4'd0,
                              age_cnt == CNT_W'(1));
            if (age_cnt == CNT_W'(1)) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_q.status;
  assign out_o.kind       = out_q.kind;
  assign out_o.txn_id     = out_q.txn_id;
  assign out_o.ready_now  = out_q.ready_now;
  assign out_o.batch_done = out_q.batch_done;
  assign out_o.done_batch = out_q.done_batch;
  assign out_o.last       = out_q.last;

  `GDDS_ASSERT_NXT(a_accept_leaves_idle, clk_i, rst_ni, in_i.valid && in_i.ready, state_q != S_IDLE)
  `GDDS_ASSERT_NOW(a_dispatch_has_entry, clk_i, rst_ni, state_q == S_CMP_DSP, age_cnt != '0)
  `GDDS_ASSERT_NOW(a_sub_slot_free, clk_i, rst_ni, state_q == S_SUB_G, !busy_q[slot_q])
  `GDDS_ASSERT_NXT(a_seq_on_submit, clk_i, rst_ni, state_q != S_SUB_FIN, $stable(next_seq_q))

endmodule

FILE: hw/rtl/gdds_age_list.sv
// ----------------------------------------------------------------------------
// gdds_age_list
// sorted list of ready ages, oldest at the head, insertion by parallel compare
// ----------------------------------------------------------------------------
module gdds_age_list import gdds_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  age_ctl_t         ctl_i,
  input  logic [31:0]      age_i,
  output logic [31:0]      head_o,
  output logic [CNT_W-1:0] count_o
);

  logic [31:0]      age_q [SLOTS];
  logic [31:0]      age_d [SLOTS];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SLOTS-1:0] keep;

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      keep[k] = (CNT_W'(k) < cnt_q) && (age_q[k] >= age_i);
    end
    for (int k = 0; k < SLOTS; k++) begin
      age_d[k] = age_q[k];
      if (ctl_i.push) begin
        // older entries stay, the new one goes right after them
        if (!keep[k]) begin
          if (k == 0) begin
            age_d[k] = age_i;
          end else if (keep[k-1]) begin
            age_d[k] = age_i;
          end else begin
            age_d[k] = age_q[k-1];
          end
        end
      end else if (ctl_i.pop) begin
        if (k < SLOTS - 1) begin
          age_d[k] = age_q[k+1];
        end
      end
    end
    cnt_d = cnt_q;
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (ctl_i.push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (ctl_i.pop) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SLOTS; k++) begin
      age_q[k] <= age_d[k];
    end
  end

  assign head_o  = age_q[0];
  assign count_o = cnt_q;

endmodule

FILE: dv/group_dependency_dispatch_scheduler_test.sv
// ----------------------------------------------------------------------------
// group_dependency_dispatch_scheduler_test
// drives open, submit and complete commands into the scheduler, predicts the
// acks and dispatches from a local dependency table and checks every result
// ----------------------------------------------------------------------------
module group_dependency_dispatch_scheduler_test;
  import gdds_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;

  gdds_in_if  cmd_if ();
  gdds_out_if res_if ();

  group_dependency_dispatch_scheduler dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // shadow dependency table
  logic [31:0] seq_ctr;
  bit          busy      [SLOTS];
  logic [31:0] slot_id   [SLOTS];
  int          indeg     [SLOTS];
  logic [63:0] grp_bits  [SLOTS];
  int          slot_tag  [SLOTS];
  int          succ      [SLOTS][GROUPS];
  int          tail      [GROUPS];
  logic [15:0] remaining [BATCHES];

  result_t expected_results [$];
  int      failures;
  int      idle_cycles;
  int      snd_idle;
  int      rcv_idle;
  int      n_submit, n_complete, n_dispatch, n_batch_done;

  task automatic push_result(status_e st, kind_e kd, logic [31:0] id, logic rdy,
                             logic bd, logic [3:0] bn, logic lst);
    result_t r;
    r.status     = st;
    r.kind       = kd;
    r.txn_id     = id;
    r.ready_now  = rdy;
    r.batch_done = bd;
    r.done_batch = bn;
    r.last       = lst;
    expected_results = {expected_results, r};
  endtask

  task automatic clear_table();
    seq_ctr = 32'd1;
    for (int s = 0; s < SLOTS; s++) busy[s] = 1'b0;
    for (int g = 0; g < GROUPS; g++) tail[g] = SLOTS;
    for (int b = 0; b < BATCHES; b++) remaining[b] = '0;
  endtask

  task automatic schedule_submit(logic [3:0] tag, logic [63:0] mask);
    int s;
    int deg;
    s = 0;
    deg = 0;
    while (s < SLOTS && busy[s]) s++;
    if (s >= SLOTS) begin
      push_result(ST_FULL, KIND_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    for (int g = 0; g < GROUPS; g++) begin
      succ[s][g] = SLOTS;
      if (mask[g]) begin
        if (tail[g] < SLOTS) begin
          succ[tail[g]][g] = s;
          deg++;
        end
        tail[g] = s;
      end
    end
    busy[s]     = 1'b1;
    slot_id[s]  = seq_ctr;
    indeg[s]    = deg;
    grp_bits[s] = mask;
    slot_tag[s] = tag % BATCHES;
    push_result(ST_OK, KIND_ACK, seq_ctr, deg == 0, 1'b0, '0, 1'b1);
    seq_ctr = seq_ctr + 32'd1;
    n_submit++;
  endtask

  task automatic schedule_complete(logic [31:0] id);
    int s;
    int t;
    int b;
    int n;
    int v;
    int j;
    bit bdone;
    bit lst;
    int woken [$];
    s = 0;
    bdone = 1'b0;
    while (s < SLOTS && !(busy[s] && slot_id[s] == id)) s++;
    if (s >= SLOTS || indeg[s] != 0) begin
      push_result(ST_BAD, KIND_ACK, id, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    busy[s] = 1'b0;
    for (int g = 0; g < GROUPS; g++) begin
      if (grp_bits[s][g]) begin
        if (tail[g] == s) tail[g] = SLOTS;
        t = succ[s][g];
        if (t < SLOTS && busy[t] && indeg[t] > 0) begin
          indeg[t]--;
          if (indeg[t] == 0) woken = {woken, t};
        end
      end
    end
    // stable sort, oldest (largest distance behind the counter) first
    for (int i = 1; i < woken.size(); i++) begin
      v = woken[i];
      j = i - 1;
      while (j >= 0 && (seq_ctr - slot_id[woken[j]]) < (seq_ctr - slot_id[v])) begin
        woken[j + 1] = woken[j];
        j--;
      end
      woken[j + 1] = v;
    end
    b = slot_tag[s];
    if (remaining[b] != 0) begin
      remaining[b]--;
      bdone = (remaining[b] == 0);
    end
    n = woken.size() + 1;
    push_result(ST_OK, KIND_ACK, id, 1'b0, n == 1 && bdone,
                (n == 1 && bdone) ? 4'(b) : 4'd0, n == 1);
    for (int i = 0; i < woken.size(); i++) begin
      lst = (i + 2 == n);
      push_result(ST_OK, KIND_DISP, slot_id[woken[i]], 1'b0, lst && bdone,
                  (lst && bdone) ? 4'(b) : 4'd0, lst);
    end
    n_complete++;
    n_dispatch += woken.size();
    if (bdone) n_batch_done++;
  endtask

  task automatic schedule_item(cmd_e cmd, logic [3:0] tag, logic [15:0] cnt,
                               logic [63:0] mask, logic [31:0] id);
    case (cmd)
      CMD_OPEN: begin
        remaining[tag % BATCHES] = cnt;
        push_result(ST_OK, KIND_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
      end
      CMD_SUBMIT:   schedule_submit(tag, mask);
      CMD_COMPLETE: schedule_complete(id);
      default:      push_result(ST_BAD, KIND_ACK, '0, 1'b0, 1'b0, '0, 1'b1);
    endcase
  endtask

  // called at a falling edge, returns at a falling edge once the command is taken
  task automatic send_command(cmd_e cmd, logic [3:0] tag, logic [15:0] cnt,
                              logic [63:0] mask, logic [31:0] id);
    while ($urandom_range(99) < snd_idle) begin
      cmd_if.valid = 1'b0;
      @(negedge clk);
    end
    cmd_if.valid       = 1'b1;
    cmd_if.command     = cmd;
    cmd_if.batch_tag   = tag;
    cmd_if.batch_count = cnt;
    cmd_if.group_mask  = mask;
    cmd_if.done_id     = id;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    schedule_item(cmd, tag, cnt, mask, id);
    @(negedge clk);
    cmd_if.valid = 1'b0;
  endtask

  function automatic int count_busy();
    int c;
    c = 0;
    for (int s = 0; s < SLOTS; s++) if (busy[s]) c++;
    return c;
  endfunction

  // id of a random dispatched transaction, zero if none
  function automatic logic [31:0] pick_dispatched();
    logic [31:0] ids [$];
    for (int s = 0; s < SLOTS; s++) if (busy[s] && indeg[s] == 0) ids = {ids, slot_id[s]};
    if (ids.size() == 0) return '0;
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  function automatic logic [63:0] random_mask();
    logic [63:0] m;
    int sel;
    sel = $urandom_range(99);
    m = '0;
    if (sel < 8) return '0;
    if (sel < 16) return {$urandom, $urandom};
    // few bits in a narrow band so groups chain up
    for (int k = $urandom_range(3, 1); k > 0; k--) m[$urandom_range(7)] = 1'b1;
    if (sel < 30) m = m << ($urandom_range(7) * 8);
    return m;
  endfunction

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic test_open_and_reserved();
    send_command(CMD_OPEN, 4'd0, 16'd1, '0, '0);
    send_command(CMD_OPEN, 4'd15, 16'hffff, '1, '1);
    send_command(CMD_OPEN, 4'd15, 16'd0, '0, '0);
    send_command(CMD_RSVD, 4'd5, 16'd3, '1, 32'h1234_5678);
    drain();
  endtask

  task automatic test_bad_completes();
    send_command(CMD_OPEN, 4'd1, 16'd1, '0, '0);
    send_command(CMD_COMPLETE, 4'd0, '0, '0, 32'd0);
    send_command(CMD_COMPLETE, 4'd0, '0, '0, 32'hffff_ffff);
    send_command(CMD_SUBMIT, 4'd1, '0, 64'h1, '0);
    send_command(CMD_SUBMIT, 4'd1, '0, 64'h1, '0);
    // second one still waits on the first
    send_command(CMD_COMPLETE, 4'd0, '0, '0, seq_ctr - 32'd1);
    send_command(CMD_COMPLETE, 4'd0, '0, '0, seq_ctr - 32'd2);
    send_command(CMD_COMPLETE, 4'd0, '0, '0, seq_ctr - 32'd2);
    send_command(CMD_COMPLETE, 4'd0, '0, '0, seq_ctr - 32'd1);
    // empty mask is ready at once, batch count already zero
    send_command(CMD_SUBMIT, 4'd1, '0, '0, '0);
    send_command(CMD_COMPLETE, 4'd0, '0, '0, seq_ctr - 32'd1);
    drain();
  endtask

  task automatic test_full_table_fanout();
    logic [31:0] root;
    send_command(CMD_OPEN, 4'd3, 16'd64, '0, '0);
    root = seq_ctr;
    send_command(CMD_SUBMIT, 4'd3, '0, '1, '0);
    for (int g = 0; g < SLOTS - 1; g++) send_command(CMD_SUBMIT, 4'd3, '0, 64'h1 << g, '0);
    send_command(CMD_SUBMIT, 4'd3, '0, 64'h1, '0);
    // releasing the root wakes every other slot
    send_command(CMD_COMPLETE, 4'd0, '0, '0, root);
    while (count_busy() != 0) send_command(CMD_COMPLETE, 4'd0, '0, '0, pick_dispatched());
    drain();
  endtask

  task automatic test_random_traffic(int items);
    int sel;
    logic [31:0] id;
    for (int i = 0; i < items; i++) begin
      sel = $urandom_range(99);
      if (sel < 6) begin
        send_command(CMD_OPEN, 4'($urandom), ($urandom_range(9) == 0) ? 16'($urandom)
                     : 16'($urandom_range(5, 1)), random_mask(), $urandom);
      end else if (sel < 9) begin
        send_command(CMD_RSVD, 4'($urandom), 16'($urandom), random_mask(), $urandom);
      end else if (sel < 14) begin
        send_command(CMD_COMPLETE, 4'($urandom), 16'($urandom), random_mask(),
                     ($urandom_range(1) == 0) ? $urandom : seq_ctr - 32'($urandom_range(8)));
      end else if (count_busy() < 6 || (sel < 55 && count_busy() < 56)) begin
        send_command(CMD_SUBMIT, 4'($urandom), 16'($urandom), random_mask(), $urandom);
      end else begin
        id = pick_dispatched();
        send_command(CMD_COMPLETE, 4'($urandom), 16'($urandom), random_mask(), id);
      end
    end
    drain();
  endtask

  always @(negedge clk) res_if.ready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk) begin
    result_t e;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result txn_id=%0h", res_if.txn_id);
        failures++;
      end else begin
        e = expected_results.pop_front();
        if (res_if.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, res_if.status);
          failures++;
        end
        if (res_if.kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, res_if.kind);
          failures++;
        end
        if (res_if.txn_id !== e.txn_id) begin
          $error("txn_id expected %0h actual %0h", e.txn_id, res_if.txn_id);
          failures++;
        end
        if (res_if.ready_now !== e.ready_now) begin
          $error("ready_now expected %0d actual %0d", e.ready_now, res_if.ready_now);
          failures++;
        end
        if (res_if.batch_done !== e.batch_done) begin
          $error("batch_done expected %0d actual %0d", e.batch_done, res_if.batch_done);
          failures++;
        end
        if (res_if.done_batch !== e.done_batch) begin
          $error("done_batch expected %0d actual %0d", e.done_batch, res_if.done_batch);
          failures++;
        end
        if (res_if.last !== e.last) begin
          $error("last expected %0d actual %0d", e.last, res_if.last);
          failures++;
        end
      end
    end
  end

  // counts cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("group_dependency_dispatch_scheduler: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.command     = CMD_OPEN;
    cmd_if.batch_tag   = '0;
    cmd_if.batch_count = '0;
    cmd_if.group_mask  = '0;
    cmd_if.done_id     = '0;
    failures     = 0;
    n_submit     = 0;
    n_complete   = 0;
    n_dispatch   = 0;
    n_batch_done = 0;
    snd_idle     = 8;
    rcv_idle     = 81;
    clear_table();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_open_and_reserved();
    test_bad_completes();
    test_full_table_fanout();
    test_random_traffic(30);
    snd_idle = 81;
    rcv_idle = 8;
    test_random_traffic(30);
    snd_idle = 0;
    rcv_idle = 0;
    test_random_traffic(30);
    while (count_busy() != 0) send_command(CMD_COMPLETE, 4'd0, '0, '0, pick_dispatched());
    drain();
    repeat (400) @(negedge clk);

    if (expected_results.size() != 0) failures++;
    $display("covered %0d submits, %0d completions, %0d dispatches, %0d finished batches",
             n_submit, n_complete, n_dispatch, n_batch_done);
    $display("including a full table, a 63-way wakeup and bad completions under stalls");
    if (failures == 0) begin
      $display("group_dependency_dispatch_scheduler: match");
    end else begin
      $display("group_dependency_dispatch_scheduler: mismatch");
    end
    $finish;
  end

endmodule
